// ----- rtl/core/light_sensor_to_pwm_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the light sensor to PWM mapper
// Each macro clocks on i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_TO_PWM_MAPPER_MACROS_SVH
`define LIGHT_SENSOR_TO_PWM_MAPPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LSPM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lspm assertion failed");

// Consequent must hold in the cycle after the antecedent
`define LSPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lspm assertion failed");

`endif

// ----- rtl/core/lspm_pkg.sv -----
// ----------------------------------------------------------------------------
// lspm_pkg
// Shared constants, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lspm_pkg;

    // Fixed-point formats
    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int FILT_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int WEIGHT_BITS = FRAC_BITS + 1;
    localparam int DUTY_BITS   = 16;

    localparam logic [WEIGHT_BITS-1:0] ONE_Q  = WEIGHT_BITS'(1) << FRAC_BITS;
    localparam logic [FILT_BITS:0]     HALF_Q = (FILT_BITS + 1)'(1) << (FRAC_BITS - 1);

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = WEIGHT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_LOW    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY_HIGH   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_INVERT      = 3'd5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sensor_low;
        logic [SAMPLE_BITS-1:0] sensor_high;
        logic [DUTY_BITS-1:0]   duty_low;
        logic [DUTY_BITS-1:0]   duty_high;
        logic [WEIGHT_BITS-1:0] smoothing_weight;
        logic                   invert_mode;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/lspm_front.sv -----
// ----------------------------------------------------------------------------
// lspm_front
// Accepts sensor words and runs the exponential moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

module lspm_front
    import lspm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_valid,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_busy,
    output logic                        o_push,
    output logic [FILT_BITS-1:0]        o_push_data,
    input  wire logic                   i_full
);

    localparam int P1_BITS = WEIGHT_BITS + SAMPLE_BITS;
    localparam int P2_BITS = WEIGHT_BITS + FILT_BITS;

    localparam logic [1:0] FS_IDLE = 2'd0;
    localparam logic [1:0] FS_MUL  = 2'd1;
    localparam logic [1:0] FS_SUM  = 2'd2;
    localparam logic [1:0] FS_PUSH = 2'd3;

    logic [1:0]             r_state, n_state;
    logic                   r_primed;
    logic [FILT_BITS-1:0]   r_filt;
    logic [SAMPLE_BITS-1:0] r_x;
    logic [P1_BITS-1:0]     r_p1;
    logic [P2_BITS-1:0]     r_p2;

    logic [WEIGHT_BITS-1:0] w_weight;
    logic [WEIGHT_BITS-1:0] w_keep;
    logic [P1_BITS:0]       w_sum;
    logic                   w_accept;

    // weight above one acts as one
    assign w_weight = (i_cfg.smoothing_weight > ONE_Q) ? ONE_Q : i_cfg.smoothing_weight;
    assign w_keep   = ONE_Q - w_weight;
    assign w_sum    = {1'b0, r_p1} + {1'b0, r_p2[P2_BITS-1:FRAC_BITS]};

    assign w_accept    = i_valid && (r_state == FS_IDLE);
    assign o_busy      = (r_state != FS_IDLE);
    assign o_push      = (r_state == FS_PUSH) && !i_full;
    assign o_push_data = r_filt;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (w_accept) begin
                    n_state = r_primed ? FS_MUL : FS_PUSH;
                end
            end
            FS_MUL:  n_state = FS_SUM;
            FS_SUM:  n_state = FS_PUSH;
            FS_PUSH: begin
                if (!i_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FS_IDLE;
            r_primed <= 1'b0;
            r_filt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_primed <= 1'b1;
                // first word loads the filter directly
                if (!r_primed) begin
                    r_filt <= {i_sample, {FRAC_BITS{1'b0}}};
                end
            end
            if (r_state == FS_SUM) begin
                r_filt <= w_sum[FILT_BITS-1:0];
            end
        end
    end

    // sample capture and product registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample;
        end
        if (r_state == FS_MUL) begin
            r_p1 <= w_weight * r_x;
            r_p2 <= w_keep * r_filt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lspm_queue.sv -----
// ----------------------------------------------------------------------------
// lspm_queue
// Short queue of filtered levels between the filter and the mapping back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lspm_queue
    import lspm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [FILT_BITS-1:0] i_data,
    input  wire logic                 i_pop,
    output logic [FILT_BITS-1:0]      o_data,
    output logic                      o_full,
    output logic                      o_empty
);

    logic [FILT_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lspm_back.sv -----
// ----------------------------------------------------------------------------
// lspm_back
// Maps a filtered level onto a duty: serial divide, clamp, invert, scale.
// ----------------------------------------------------------------------------
`default_nettype none

module lspm_back
    import lspm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic [FILT_BITS-1:0]   i_filt,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [DUTY_BITS-1:0]        o_duty,
    output logic [SAMPLE_BITS-1:0]      o_level,
    input  wire logic                   i_stall
);

    localparam int QUO_BITS = FRAC_BITS + 1;
    localparam int TOP_BITS = FILT_BITS - QUO_BITS;
    localparam int CNT_BITS = $clog2(QUO_BITS);
    localparam int ACC_BITS = DUTY_BITS + FRAC_BITS + 3;

    localparam logic [2:0] BS_IDLE = 3'd0;
    localparam logic [2:0] BS_DIV  = 3'd1;
    localparam logic [2:0] BS_FRAC = 3'd2;
    localparam logic [2:0] BS_MUL  = 3'd3;
    localparam logic [2:0] BS_SUM  = 3'd4;
    localparam logic [2:0] BS_OUT  = 3'd5;

    logic [2:0]                r_state;
    logic [CNT_BITS-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0]    r_rem;
    logic [QUO_BITS-1:0]       r_num;
    logic [QUO_BITS-1:0]       r_quo;
    logic [WEIGHT_BITS-1:0]    r_n;
    logic signed [ACC_BITS-1:0] r_prod;
    logic [DUTY_BITS-1:0]      r_duty;
    logic [SAMPLE_BITS-1:0]    r_level;
    logic                      r_out_valid;
    logic [DUTY_BITS-1:0]      r_out_duty;
    logic [SAMPLE_BITS-1:0]    r_out_level;

    logic                      w_empty_range;
    logic [SAMPLE_BITS-1:0]    w_span;
    logic [FILT_BITS-1:0]      w_base;
    logic [FILT_BITS-1:0]      w_num;
    logic [SAMPLE_BITS:0]      w_trial;
    logic                      w_ge;
    logic [FILT_BITS:0]        w_lvl_sum;
    logic [SAMPLE_BITS:0]      w_lvl;
    logic [WEIGHT_BITS-1:0]    w_clamped;
    logic signed [DUTY_BITS:0] w_diff;
    logic signed [ACC_BITS-1:0] w_acc;
    logic                      w_out_free;

    // range and numerator
    assign w_empty_range = (i_cfg.sensor_high <= i_cfg.sensor_low);
    assign w_span        = i_cfg.sensor_high - i_cfg.sensor_low;
    assign w_base        = {i_cfg.sensor_low, {FRAC_BITS{1'b0}}};
    assign w_num         = i_filt - w_base;

    // one restoring divide step
    assign w_trial = {r_rem, r_num[QUO_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, w_span});

    // rounded level, saturated
    assign w_lvl_sum = {1'b0, i_filt} + HALF_Q;
    assign w_lvl     = w_lvl_sum[FILT_BITS:FRAC_BITS];

    // fraction clamp and duty arithmetic
    assign w_clamped = (r_quo > ONE_Q) ? ONE_Q : r_quo;
    assign w_diff    = $signed({1'b0, i_cfg.duty_high}) - $signed({1'b0, i_cfg.duty_low});
    assign w_acc     = $signed({3'b000, i_cfg.duty_low, {FRAC_BITS{1'b0}}}) + r_prod
                     + $signed(ACC_BITS'(HALF_Q));

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop      = (r_state == BS_IDLE) && !i_empty;

    assign o_valid = r_out_valid;
    assign o_duty  = r_out_duty;
    assign o_level = r_out_level;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                BS_IDLE: begin
                    if (!i_empty) begin
                        if (w_empty_range) begin
                            r_state <= BS_OUT;
                        end else if ((i_filt <= w_base) ||
                                     ({1'b0, w_num[FILT_BITS-1:QUO_BITS]} >= w_span)) begin
                            r_state <= BS_FRAC;
                        end else begin
                            r_state <= BS_DIV;
                        end
                    end
                end
                BS_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= BS_FRAC;
                    end
                end
                BS_FRAC: r_state <= BS_MUL;
                BS_MUL:  r_state <= BS_SUM;
                BS_SUM:  r_state <= BS_OUT;
                BS_OUT: begin
                    if (w_out_free) begin
                        r_state <= BS_IDLE;
                    end
                end
                default: r_state <= BS_IDLE;
            endcase

            // output word register
            if ((r_state == BS_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_level <= w_lvl[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : w_lvl[SAMPLE_BITS-1:0];
                r_duty  <= i_cfg.duty_low;
                r_cnt   <= CNT_BITS'(QUO_BITS - 1);
                r_num   <= w_num[QUO_BITS-1:0];
                r_rem   <= {{(SAMPLE_BITS - TOP_BITS){1'b0}}, w_num[FILT_BITS-1:QUO_BITS]};
                // quotient at or above two: clamp to one
                r_quo   <= ((i_filt > w_base) &&
                            ({1'b0, w_num[FILT_BITS-1:QUO_BITS]} >= w_span)) ? ONE_Q : '0;
            end
            BS_DIV: begin
                r_rem <= w_ge ? SAMPLE_BITS'(w_trial - {1'b0, w_span})
                              : w_trial[SAMPLE_BITS-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
                r_num <= {r_num[QUO_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
            end
            BS_FRAC: begin
                r_n <= i_cfg.invert_mode ? (ONE_Q - w_clamped) : w_clamped;
            end
            BS_MUL: begin
                r_prod <= $signed({{(ACC_BITS - WEIGHT_BITS){1'b0}}, r_n})
                        * $signed({{(ACC_BITS - DUTY_BITS - 1){w_diff[DUTY_BITS]}}, w_diff});
            end
            BS_SUM: begin
                r_duty <= w_acc[DUTY_BITS+FRAC_BITS-1:FRAC_BITS];
            end
            BS_OUT: begin
                if (w_out_free) begin
                    r_out_duty  <= r_duty;
                    r_out_level <= r_level;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/light_sensor_to_pwm_mapper.sv -----
// ----------------------------------------------------------------------------
// light_sensor_to_pwm_mapper
// Path from accepted word to result: filter, queue pop, 17 divide steps, scale
// (fraction, multiply, sum), output register; shorter when the range is empty,
// when the divide is skipped at the range ends, or for the first word.
// The filter can take new words while the bit-serial divider works on older ones.
// Reset is synchronous: filter unprimed, registers to defaults, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module light_sensor_to_pwm_mapper
    import lspm_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0]   i_sensor_sample,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [DUTY_BITS-1:0]          o_duty_value,
    output logic [SAMPLE_BITS-1:0]        o_smoothed_level
);

    t_cfg                 r_cfg;
    logic                 w_front_busy;
    logic                 w_push;
    logic [FILT_BITS-1:0] w_push_data;
    logic                 w_pop;
    logic [FILT_BITS-1:0] w_pop_data;
    logic                 w_full;
    logic                 w_empty;

    assign o_in_stall = w_front_busy || !i_rst_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_low       <= '0;
            r_cfg.sensor_high      <= '1;
            r_cfg.duty_low         <= '0;
            r_cfg.duty_high        <= '1;
            r_cfg.smoothing_weight <= ONE_Q;
            r_cfg.invert_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENSOR_LOW:  r_cfg.sensor_low       <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_SENSOR_HIGH: r_cfg.sensor_high      <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_DUTY_LOW:    r_cfg.duty_low         <= i_cfg_data[DUTY_BITS-1:0];
                REG_DUTY_HIGH:   r_cfg.duty_high        <= i_cfg_data[DUTY_BITS-1:0];
                REG_WEIGHT:      r_cfg.smoothing_weight <= i_cfg_data[WEIGHT_BITS-1:0];
                REG_INVERT:      r_cfg.invert_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lspm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_in_valid && i_rst_n),
        .i_sample    (i_sensor_sample),
        .o_busy      (w_front_busy),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    lspm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lspm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_filt  (w_pop_data),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .o_duty  (o_duty_value),
        .o_level (o_smoothed_level),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- rtl/core/lspm_checker.sv -----
// ----------------------------------------------------------------------------
// lspm_checker
// Port-level checks on the mapper, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "light_sensor_to_pwm_mapper_macros.svh"

module lspm_checker
    import lspm_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_stall,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_stall,
    input wire logic [DUTY_BITS-1:0]     o_duty_value,
    input wire logic [SAMPLE_BITS-1:0]   o_smoothed_level
);

    logic       w_in_take;
    logic       w_out_take;
    logic       w_out_hold;
    logic [3:0] r_in_flight;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = o_out_valid && !i_out_stall;
    assign w_out_hold = o_out_valid && i_out_stall;

    // words taken in and not yet handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight <= '0;
        end else begin
            r_in_flight <= r_in_flight + {3'b000, w_in_take} - {3'b000, w_out_take};
        end
    end

    // a stalled result word stays valid and unchanged
    `LSPM_ASSERT_NEXT(a_out_valid_holds, w_out_hold, o_out_valid)
    `LSPM_ASSERT_NEXT(a_out_word_holds, w_out_hold,
                      $stable(o_duty_value) && $stable(o_smoothed_level))

    // the filter is busy right after it takes a word
    `LSPM_ASSERT_NEXT(a_front_busy, w_in_take, o_in_stall)

    // every result word stems from a word taken earlier
    `LSPM_ASSERT_SAME(a_result_has_word, o_out_valid, r_in_flight != '0)

endmodule

bind light_sensor_to_pwm_mapper lspm_checker u_lspm_checker (.*);

`default_nettype wire

// ----- sim/tb_light_sensor_to_pwm_mapper.sv -----
// ----------------------------------------------------------------------------
// tb_light_sensor_to_pwm_mapper
// Drives sensor samples and register writes into the mapper and compares each
// output word with a local model of the smoothing filter and the duty mapping.
// Directed cases come first, then random samples under varied settings.
// Both sides idle and stall at random, and one long output stall fills the
// block.
// ----------------------------------------------------------------------------

module tb_light_sensor_to_pwm_mapper;
    import lspm_pkg::*;

    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int SETTLE_CYCLES     = 40;
    localparam int ITEMS_PER_SETTING = 106;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS       = 10;

    // Indexes past the register list; writes to them must be ignored
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [DUTY_BITS-1:0]   duty;
        logic [SAMPLE_BITS-1:0] level;
    } t_duty_word;

    // Filter and duty model plus the queue of expected output words
    class lamp_duty_checker;
        t_cfg              cfg;
        longint unsigned   filt_q;
        bit                primed;
        t_duty_word        pending_duty[$];
        int                mismatches;

        function new();
            cfg.sensor_low       = '0;
            cfg.sensor_high      = '1;
            cfg.duty_low         = '0;
            cfg.duty_high        = '1;
            cfg.smoothing_weight = ONE_Q;
            cfg.invert_mode      = 1'b0;
            filt_q               = 0;
            primed               = 1'b0;
            mismatches           = 0;
        endfunction

        // Register write; unknown indexes are dropped, extra bits masked
        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_SENSOR_LOW:  cfg.sensor_low       = data[SAMPLE_BITS-1:0];
                REG_SENSOR_HIGH: cfg.sensor_high      = data[SAMPLE_BITS-1:0];
                REG_DUTY_LOW:    cfg.duty_low         = data[DUTY_BITS-1:0];
                REG_DUTY_HIGH:   cfg.duty_high        = data[DUTY_BITS-1:0];
                REG_WEIGHT:      cfg.smoothing_weight = data[WEIGHT_BITS-1:0];
                REG_INVERT:      cfg.invert_mode      = data[0];
                default: ;
            endcase
        endfunction

        // Accepted sample: update the filter and queue the expected word
        function void note_sample(logic [SAMPLE_BITS-1:0] x);
            longint unsigned unit, w, xq, lvl, base, span, frac;
            longint          acc;
            t_duty_word      word;
            unit = 64'd1 << FRAC_BITS;
            xq   = 64'(x) << FRAC_BITS;
            w    = (64'(cfg.smoothing_weight) > unit) ? unit : 64'(cfg.smoothing_weight);
            if (!primed) begin
                filt_q = xq;
                primed = 1'b1;
            end else begin
                filt_q = (w * xq + (unit - w) * filt_q) >> FRAC_BITS;
            end

            lvl = (filt_q + (unit >> 1)) >> FRAC_BITS;
            if (lvl > 64'(SAMPLE_BITS'('1)))
                lvl = 64'(SAMPLE_BITS'('1));
            word.level = lvl[SAMPLE_BITS-1:0];

            if (cfg.sensor_high <= cfg.sensor_low) begin
                // empty sensor range: duty sits at its low end
                word.duty = cfg.duty_low;
            end else begin
                base = 64'(cfg.sensor_low) << FRAC_BITS;
                span = 64'(cfg.sensor_high) - 64'(cfg.sensor_low);
                frac = (filt_q <= base) ? 64'd0 : (filt_q - base) / span;
                if (frac > unit)
                    frac = unit;
                if (cfg.invert_mode)
                    frac = unit - frac;
                acc = longint'(64'(cfg.duty_low) << FRAC_BITS)
                    + longint'(frac) * (longint'(64'(cfg.duty_high))
                                        - longint'(64'(cfg.duty_low)))
                    + longint'(unit >> 1);
                if (acc < 0)
                    acc = 0;
                word.duty = DUTY_BITS'(64'(acc) >> FRAC_BITS);
            end
            pending_duty.push_back(word);
        endfunction

        // Accepted output word against the oldest expectation
        function void check_word(logic [DUTY_BITS-1:0] duty, logic [SAMPLE_BITS-1:0] level);
            t_duty_word want;
            if (pending_duty.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: duty=%0d level=%0d", duty, level);
                return;
            end
            want = pending_duty.pop_front();
            if (want.duty !== duty || want.level !== level) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: duty exp=%0d got=%0d, level exp=%0d got=%0d",
                             want.duty, duty, want.level, level);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_cfg_we        = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data      = '0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic [SAMPLE_BITS-1:0]   i_sensor_sample = '0;
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic [DUTY_BITS-1:0]     o_duty_value;
    logic [SAMPLE_BITS-1:0]   o_smoothed_level;

    lamp_duty_checker duty_model = new();

    int idle_pct      = 0;
    int stall_pct     = 0;
    int long_hold_len = 0;
    int cycle_count   = 0;

    light_sensor_to_pwm_mapper u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sensor_sample  (i_sensor_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_duty_value     (o_duty_value),
        .o_smoothed_level (o_smoothed_level)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Output side: random stall, plus one long hold-off counted here
    initial begin : out_side
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (held < long_hold_len) begin
                i_out_stall <= 1'b1;
                held++;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Handshake monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                duty_model.note_sample(i_sensor_sample);
            if (o_out_valid && !i_out_stall)
                duty_model.check_word(o_duty_value, o_smoothed_level);
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_light_sensor_to_pwm_mapper NOT OK");
            $finish;
        end
    end

    // One sample word; valid stays high unless a gap is drawn
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sensor_sample <= x;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    // Stop sending and wait until every expected word is out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (duty_model.pending_duty.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        duty_model.set_reg(idx, data);
    endtask

    task automatic cfg_end();
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [WEIGHT_BITS-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE_Q;
            2:       return WEIGHT_BITS'($urandom_range(65537, 131071));
            3:       return WEIGHT_BITS'($urandom_range(1, 255));
            default: return WEIGHT_BITS'($urandom_range(0, 65536));
        endcase
    endfunction

    // Half full-scale, half around the calibrated sensor range
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int lo, hi;
        if ($urandom_range(0, 1))
            return SAMPLE_BITS'($urandom);
        lo = int'(duty_model.cfg.sensor_low) - 64;
        hi = int'(duty_model.cfg.sensor_high) + 64;
        if (lo < 0)
            lo = 0;
        if (hi > 4095)
            hi = 4095;
        return SAMPLE_BITS'($urandom_range(lo, hi));
    endfunction

    // Full register set; kind 0 is the widest range, kind 1 an empty range
    task automatic apply_setting(input int kind);
        logic [SAMPLE_BITS-1:0] s_lo, s_hi, tmp;
        logic [DUTY_BITS-1:0]   d_lo, d_hi;
        logic [WEIGHT_BITS-1:0] wt;
        d_lo = DUTY_BITS'($urandom);
        d_hi = DUTY_BITS'($urandom);
        wt   = pick_weight();
        case (kind)
            0: begin
                s_lo = '0;
                s_hi = '1;
                d_lo = $urandom_range(0, 1) ? '0 : '1;
                d_hi = ~d_lo;
                wt   = ONE_Q;
            end
            1: begin
                s_lo = SAMPLE_BITS'($urandom);
                s_hi = SAMPLE_BITS'($urandom_range(0, int'(s_lo)));
            end
            default: begin
                s_lo = SAMPLE_BITS'($urandom);
                s_hi = SAMPLE_BITS'($urandom);
                if (s_hi < s_lo) begin
                    tmp  = s_lo;
                    s_lo = s_hi;
                    s_hi = tmp;
                end
            end
        endcase
        // upper data bits carry junk that the block must mask
        write_reg(REG_SENSOR_LOW,  {5'($urandom), s_lo});
        write_reg(REG_SENSOR_HIGH, {5'($urandom), s_hi});
        write_reg(REG_DUTY_LOW,    {1'($urandom), d_lo});
        write_reg(REG_DUTY_HIGH,   {1'($urandom), d_hi});
        write_reg(REG_WEIGHT,      wt);
        write_reg(REG_INVERT,      CFG_DATA_BITS'($urandom));
        if (kind == 3) begin
            write_reg(REG_UNUSED_6, CFG_DATA_BITS'($urandom));
            write_reg(REG_UNUSED_7, CFG_DATA_BITS'($urandom));
        end
        cfg_end();
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first sample primes, unit weight tracks the input
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd2048);
        send_sample(12'd1);
        drain();

        // Zero weight: filter holds
        write_reg(REG_WEIGHT, 17'd0);
        cfg_end();
        send_sample(12'd4095);
        send_sample(12'd0);
        drain();

        // Weight above one acts as one; inverted fraction
        write_reg(REG_WEIGHT, 17'h18000);
        write_reg(REG_INVERT, 17'd1);
        cfg_end();
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2047);
        drain();

        // Narrow sensor range, falling duty range, half weight
        write_reg(REG_WEIGHT,      17'd32768);
        write_reg(REG_INVERT,      17'd0);
        write_reg(REG_SENSOR_LOW,  17'd1000);
        write_reg(REG_SENSOR_HIGH, 17'd3000);
        write_reg(REG_DUTY_LOW,    17'd60000);
        write_reg(REG_DUTY_HIGH,   17'd100);
        cfg_end();
        send_sample(12'd1000);
        send_sample(12'd3000);
        send_sample(12'd999);
        send_sample(12'd3001);
        send_sample(12'd2000);
        drain();

        // Empty range: equal bounds, then reversed bounds
        write_reg(REG_SENSOR_LOW,  17'd2048);
        write_reg(REG_SENSOR_HIGH, 17'd2048);
        cfg_end();
        send_sample(12'd2048);
        send_sample(12'd100);
        drain();
        write_reg(REG_SENSOR_LOW,  17'd4095);
        write_reg(REG_SENSOR_HIGH, 17'd0);
        cfg_end();
        send_sample(12'd4095);
        drain();

        // Masked write data, ignored indexes, flat duty range
        write_reg(REG_SENSOR_LOW,  17'h1F000);
        write_reg(REG_SENSOR_HIGH, 17'd4095);
        write_reg(REG_DUTY_LOW,    17'd65535);
        write_reg(REG_DUTY_HIGH,   17'd65535);
        write_reg(REG_UNUSED_6,    17'h1FFFF);
        write_reg(REG_UNUSED_7,    17'd0);
        cfg_end();
        send_sample(12'd1234);
        drain();

        // Random part: four idling mixes, four settings each
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 67; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int kind = 0; kind < 4; kind++) begin
                apply_setting(kind);
                // long output hold while samples keep coming
                if (phase == 0 && kind == 2)
                    long_hold_len = LONG_HOLD_CYCLES;
                for (int n = 0; n < ITEMS_PER_SETTING; n++)
                    send_sample(pick_sample());
                drain();
            end
        end

        if (duty_model.mismatches == 0 && duty_model.pending_duty.size() == 0) begin
            $display("tb_light_sensor_to_pwm_mapper OK");
        end else begin
            $display("tb_light_sensor_to_pwm_mapper NOT OK");
        end
        $finish;
    end

endmodule

// ----- light_sensor_to_pwm_mapper.f -----
+incdir+rtl/core
rtl/core/lspm_pkg.sv
rtl/core/lspm_front.sv
rtl/core/lspm_queue.sv
rtl/core/lspm_back.sv
rtl/core/light_sensor_to_pwm_mapper.sv
rtl/core/lspm_checker.sv
sim/tb_light_sensor_to_pwm_mapper.sv
